// ===== rtl/scrb_pkg.sv =====
// ----------------------------------------------------------------------------
// scrb_pkg
// Shared types and constants for the serial channel ring buffers.
// ----------------------------------------------------------------------------
package scrb_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RX_COUNT_W = 10;
  localparam int unsigned TX_COUNT_W = 7;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned TXIDX_W    = 7;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    ACT_RX    = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_TXRDY = 3'd3,
    ACT_TICK  = 3'd4,
    ACT_CLEAR = 3'd5
  } action_e;

  typedef enum logic {
    CFG_IDLE_THRESHOLD = 1'b0,
    CFG_TX_DONE_INDEX  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic tx_irq;
    logic overrun;
    logic idle;
    logic tx_done;
  } status_t;

endpackage

// ===== rtl/serial_channel_ring_buffers_top.sv =====
// ----------------------------------------------------------------------------
// serial_channel_ring_buffers_top
// Receive and transmit byte rings of one serial channel, with idle timer.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start_i high and busy_o low;
//   action_i picks the operation (line byte received, host read, host write,
//   transmitter ready, tick, clear) and byte_i carries the byte for the
//   receive and host write operations.
//   Exactly one result follows each request, in the next cycle, shown for a
//   single cycle with done_o high. Results are registered, the read data by
//   the registered read port of the ring memories; a new request may be
//   issued every cycle, so busy_o stays low.
//   Both rings sit in single-write, single-read synchronous memories. A pop
//   reads the entry at the read pointer on the edge that takes the request,
//   and a push writes at the write pointer; the two never name the same entry
//   while the ring holds data.
//   Configuration writes go through cfg_we_i / cfg_idx_i / cfg_data_i at any
//   edge while no request is in flight. Writing the idle threshold restarts
//   the idle counter.
//   Reset empties both rings and clears the flags, idle counter and pointers;
//   the memory contents are left as they are. The receiver cannot stall, so
//   no result is ever held back.
// ----------------------------------------------------------------------------
module serial_channel_ring_buffers_top
  import scrb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 1024,
  parameter int unsigned TX_DEPTH = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              action_i,
  input  logic [BYTE_W-1:0]       byte_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic                    done_o,
  output logic [BYTE_W-1:0]       read_data_o,
  output logic                    read_valid_o,
  output logic                    push_accepted_o,
  output logic [BYTE_W-1:0]       line_byte_o,
  output logic                    line_valid_o,
  output logic [RX_COUNT_W-1:0]   rx_count_o,
  output logic [TX_COUNT_W-1:0]   tx_count_o,
  output logic                    tx_irq_enable_o,
  output logic                    overrun_o,
  output logic                    idle_flag_o,
  output logic                    tx_done_o
);

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned RXCW  = (RX_AW > RX_COUNT_W) ? RX_AW : RX_COUNT_W;
  localparam int unsigned TXCW  = (TX_AW > TX_COUNT_W) ? TX_AW : TX_COUNT_W;
  localparam int unsigned TXDW  = (TX_AW > TXIDX_W) ? TX_AW : TXIDX_W;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_SPAN = RX_AW'(RX_DEPTH);
  localparam logic [TX_AW-1:0] TX_SPAN = TX_AW'(TX_DEPTH);

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

  logic                  accept;
  action_e               act;
  logic [RX_AW-1:0]      rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d, rx_wp_nxt, rx_rp_nxt;
  logic [TX_AW-1:0]      tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d, tx_wp_nxt, tx_rp_nxt;
  logic                  rx_we, tx_we;
  logic                  rx_empty, tx_empty;
  logic [THR_W-1:0]      idle_cnt_q, idle_cnt_d, idle_inc;
  logic [THR_W-1:0]      idle_thr_q;
  logic [TXIDX_W-1:0]    tx_done_idx_q;
  status_t               stat_q, stat_d;
  logic [BYTE_W-1:0]     rx_rdata_q, tx_rdata_q;
  logic                  done_q;
  logic                  read_valid_q, read_valid_d;
  logic                  push_acc_q, push_acc_d;
  logic                  line_valid_q, line_valid_d;
  logic [RX_AW-1:0]      rx_cnt;
  logic [TX_AW-1:0]      tx_cnt;
  logic [RXCW-1:0]       rx_cnt_wide;
  logic [TXCW-1:0]       tx_cnt_wide;
  logic [RX_COUNT_W-1:0] rx_count_q;
  logic [TX_COUNT_W-1:0] tx_count_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign act    = action_e'(action_i);

  assign rx_wp_nxt = (rx_wp_q == RX_LAST) ? '0 : rx_wp_q + 1'b1;
  assign rx_rp_nxt = (rx_rp_q == RX_LAST) ? '0 : rx_rp_q + 1'b1;
  assign tx_wp_nxt = (tx_wp_q == TX_LAST) ? '0 : tx_wp_q + 1'b1;
  assign tx_rp_nxt = (tx_rp_q == TX_LAST) ? '0 : tx_rp_q + 1'b1;
  assign rx_empty  = (rx_rp_q == rx_wp_q);
  assign tx_empty  = (tx_rp_q == tx_wp_q);
  assign idle_inc  = idle_cnt_q + 1'b1;

  always_comb begin
    rx_wp_d      = rx_wp_q;
    rx_rp_d      = rx_rp_q;
    tx_wp_d      = tx_wp_q;
    tx_rp_d      = tx_rp_q;
    idle_cnt_d   = idle_cnt_q;
    stat_d       = stat_q;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    read_valid_d = 1'b0;
    push_acc_d   = 1'b0;
    line_valid_d = 1'b0;
    if (accept) begin
      unique case (act)
        ACT_RX: begin
          idle_cnt_d = '0;
          if (rx_wp_nxt == rx_rp_q) begin
            stat_d.overrun = 1'b1;
          end else begin
            rx_we   = 1'b1;
            rx_wp_d = rx_wp_nxt;
          end
        end
        ACT_READ: begin
          if (!rx_empty) begin
            read_valid_d = 1'b1;
            rx_rp_d      = rx_rp_nxt;
          end
        end
        ACT_WRITE: begin
          if (tx_wp_nxt != tx_rp_q) begin
            tx_we         = 1'b1;
            tx_wp_d       = tx_wp_nxt;
            push_acc_d    = 1'b1;
            stat_d.tx_irq = 1'b1;
          end
        end
        ACT_TXRDY: begin
          stat_d.idle = 1'b0;
          if (!tx_empty) begin
            line_valid_d   = 1'b1;
            tx_rp_d        = tx_rp_nxt;
            stat_d.tx_done = (TXDW'(tx_rp_nxt) == TXDW'(tx_done_idx_q));
            if (tx_rp_nxt == tx_wp_q) begin
              stat_d.tx_irq = 1'b0;
            end
          end else begin
            stat_d.tx_irq = 1'b0;
          end
        end
        ACT_TICK: begin
          idle_cnt_d = idle_inc;
          if (idle_inc > idle_thr_q) begin
            stat_d.idle = 1'b1;
          end
        end
        ACT_CLEAR: begin
          rx_wp_d        = '0;
          rx_rp_d        = '0;
          tx_wp_d        = '0;
          tx_rp_d        = '0;
          stat_d.idle    = 1'b0;
          stat_d.tx_done = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // A threshold write restarts the idle count.
    if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_IDLE_THRESHOLD)) begin
      idle_cnt_d = '0;
    end
  end

  // Fill counts modulo the ring depth, then cut to the result width.
  assign rx_cnt      = (rx_wp_d >= rx_rp_d) ? rx_wp_d - rx_rp_d : rx_wp_d - rx_rp_d + RX_SPAN;
  assign tx_cnt      = (tx_wp_d >= tx_rp_d) ? tx_wp_d - tx_rp_d : tx_wp_d - tx_rp_d + TX_SPAN;
  assign rx_cnt_wide = RXCW'(rx_cnt);
  assign tx_cnt_wide = TXCW'(tx_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q       <= '0;
      rx_rp_q       <= '0;
      tx_wp_q       <= '0;
      tx_rp_q       <= '0;
      idle_cnt_q    <= '0;
      idle_thr_q    <= '1;
      tx_done_idx_q <= '0;
      stat_q        <= '0;
      done_q        <= 1'b0;
      read_valid_q  <= 1'b0;
      push_acc_q    <= 1'b0;
      line_valid_q  <= 1'b0;
      rx_count_q    <= '0;
      tx_count_q    <= '0;
    end else begin
      rx_wp_q      <= rx_wp_d;
      rx_rp_q      <= rx_rp_d;
      tx_wp_q      <= tx_wp_d;
      tx_rp_q      <= tx_rp_d;
      idle_cnt_q   <= idle_cnt_d;
      stat_q       <= stat_d;
      done_q       <= accept;
      read_valid_q <= read_valid_d;
      push_acc_q   <= push_acc_d;
      line_valid_q <= line_valid_d;
      rx_count_q   <= rx_cnt_wide[RX_COUNT_W-1:0];
      tx_count_q   <= tx_cnt_wide[TX_COUNT_W-1:0];
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_IDLE_THRESHOLD: idle_thr_q    <= cfg_data_i[THR_W-1:0];
          CFG_TX_DONE_INDEX:  tx_done_idx_q <= cfg_data_i[TXIDX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Ring memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wp_q] <= byte_i;
    end
    rx_rdata_q <= rx_mem[rx_rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_wp_q] <= byte_i;
    end
    tx_rdata_q <= tx_mem[tx_rp_q];
  end

  assign done_o          = done_q;
  assign read_data_o     = read_valid_q ? rx_rdata_q : '0;
  assign read_valid_o    = read_valid_q;
  assign push_accepted_o = push_acc_q;
  assign line_byte_o     = line_valid_q ? tx_rdata_q : '0;
  assign line_valid_o    = line_valid_q;
  assign rx_count_o      = rx_count_q;
  assign tx_count_o      = tx_count_q;
  assign tx_irq_enable_o = stat_q.tx_irq;
  assign overrun_o       = stat_q.overrun;
  assign idle_flag_o     = stat_q.idle;
  assign tx_done_o       = stat_q.tx_done;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without request");

  a_single_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({read_valid_o, push_accepted_o, line_valid_o}) <= 1)
    else $error("more than one ring operation in one result");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(rx_wp_q) < RX_DEPTH) && (32'(rx_rp_q) < RX_DEPTH) &&
    (32'(tx_wp_q) < TX_DEPTH) && (32'(tx_rp_q) < TX_DEPTH))
    else $error("ring pointer beyond depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (act == ACT_CLEAR)) |=> ((rx_count_o == '0) && (tx_count_o == '0)))
    else $error("clear left data in a ring");

endmodule
